FILE: rtl/euler_xyz_to_rotation_matrix_assert.svh
// Assertion macros shared by the rotation matrix block.
`ifndef EULER_XYZ_TO_ROTATION_MATRIX_ASSERT_SVH
`define EULER_XYZ_TO_ROTATION_MATRIX_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define EXR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define EXR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/exr_pkg.sv
package exr_pkg;

    localparam int OutFracBits    = 14;
    localparam int CordicSteps    = 18;
    localparam int CordicGroups   = 6;
    localparam int CordicPerStage = CordicSteps / CordicGroups;
    // Reduction stage, CORDIC stages, two product stages, rounding stage.
    localparam int PipeDepth      = CordicGroups + 4;
    localparam int FullTurn       = 46080;
    localparam int QuarterTurn    = 11520;
    localparam int CordicGain     = 652032874;

    // Q2.30 working values; products of two are taken at 66 bits.
    typedef logic signed [32:0] q30_t;
    typedef logic signed [23:0] ang_t;

    typedef struct packed {
        q30_t s;
        q30_t c;
    } sc_t;

    function automatic ang_t atan_deg(input int i);
        ang_t t;
        unique case (i)
            0:       t = 24'sd2949120;
            1:       t = 24'sd1740967;
            2:       t = 24'sd919879;
            3:       t = 24'sd466945;
            4:       t = 24'sd234379;
            5:       t = 24'sd117304;
            6:       t = 24'sd58666;
            7:       t = 24'sd29335;
            8:       t = 24'sd14668;
            9:       t = 24'sd7334;
            10:      t = 24'sd3667;
            11:      t = 24'sd1833;
            12:      t = 24'sd917;
            13:      t = 24'sd458;
            14:      t = 24'sd229;
            15:      t = 24'sd115;
            16:      t = 24'sd57;
            17:      t = 24'sd29;
            default: t = '0;
        endcase
        return t;
    endfunction

    // Q30 product taken back to Q30, floor.
    function automatic q30_t mul_q30(input q30_t a, input q30_t b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return q30_t'(p >>> 30);
    endfunction

endpackage

FILE: rtl/exr_sincos.sv
module exr_sincos
    import exr_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output sc_t                sc
);

    // Stage 0: reduce modulo a full turn, split off quadrant.
    logic signed [16:0] red;
    logic [15:0]        a_mod;
    logic [1:0]         quad_next;
    logic [13:0]        rest_next;

    always_comb
    begin
        red = 17'(angle);
        if (red < 0)
            red = red + 17'(FullTurn);
        if (red < 0)
            red = red + 17'(FullTurn);
        if (red >= 17'(FullTurn))
            red = red - 17'(FullTurn);
        a_mod = red[15:0];
        if (a_mod >= 16'(3 * QuarterTurn))
        begin
            quad_next = 2'd3;
            rest_next = 14'(a_mod - 16'(3 * QuarterTurn));
        end
        else if (a_mod >= 16'(2 * QuarterTurn))
        begin
            quad_next = 2'd2;
            rest_next = 14'(a_mod - 16'(2 * QuarterTurn));
        end
        else if (a_mod >= 16'(QuarterTurn))
        begin
            quad_next = 2'd1;
            rest_next = 14'(a_mod - 16'(QuarterTurn));
        end
        else
        begin
            quad_next = 2'd0;
            rest_next = 14'(a_mod);
        end
    end

    q30_t       x_reg [CordicGroups+1];
    q30_t       y_reg [CordicGroups+1];
    ang_t       z_reg [CordicGroups+1];
    logic [1:0] q_reg [CordicGroups+1];
    q30_t       x_next [CordicGroups];
    q30_t       y_next [CordicGroups];
    ang_t       z_next [CordicGroups];

    // Three CORDIC iterations per stage.
    always_comb
    begin
        q30_t xt, yt, xn, yn;
        ang_t zt;
        int   sh;
        for (int g = 0; g < CordicGroups; g++)
        begin
            xt = x_reg[g];
            yt = y_reg[g];
            zt = z_reg[g];
            for (int k = 0; k < CordicPerStage; k++)
            begin
                sh = g * CordicPerStage + k;
                if (zt >= 0)
                begin
                    xn = xt - (yt >>> sh);
                    yn = yt + (xt >>> sh);
                    zt = zt - atan_deg(sh);
                end
                else
                begin
                    xn = xt + (yt >>> sh);
                    yn = yt - (xt >>> sh);
                    zt = zt + atan_deg(sh);
                end
                xt = xn;
                yt = yn;
            end
            x_next[g] = xt;
            y_next[g] = yt;
            z_next[g] = zt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= q30_t'(CordicGain);
            y_reg[0] <= '0;
            z_reg[0] <= ang_t'({rest_next, 9'd0});
            q_reg[0] <= quad_next;
            for (int g = 0; g < CordicGroups; g++)
            begin
                x_reg[g+1] <= x_next[g];
                y_reg[g+1] <= y_next[g];
                z_reg[g+1] <= z_next[g];
                q_reg[g+1] <= q_reg[g];
            end
        end
    end

    always_comb
    begin
        unique case (q_reg[CordicGroups])
            2'd1:    sc = '{s: x_reg[CordicGroups],  c: -y_reg[CordicGroups]};
            2'd2:    sc = '{s: -y_reg[CordicGroups], c: -x_reg[CordicGroups]};
            2'd3:    sc = '{s: -x_reg[CordicGroups], c: y_reg[CordicGroups]};
            default: sc = '{s: y_reg[CordicGroups],  c: x_reg[CordicGroups]};
        endcase
    end

endmodule

FILE: rtl/euler_xyz_to_rotation_matrix.sv
// Channel | Handshake     | Payload
// in      | valid / ready | angle_x angle_y angle_z (deg*128)
// out     | out_valid / out_ready | m00..m22 (Q1.14)
// One angle triple enters per cycle while the output is not stalled; the depth is
// set by a reduction stage, the 18-step CORDIC at three steps per stage, two
// multiplier stages and a rounding stage.
// Reset clears only the valid bits; data registers carry no reset.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module euler_xyz_to_rotation_matrix
    import exr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);

    `include "euler_xyz_to_rotation_matrix_assert.svh"

    logic [PipeDepth-1:0] vld_reg;
    logic                 en;

    // Advance when the output slot is empty or being drained.
    assign en        = !vld_reg[PipeDepth-1] || out_ready;
    assign ready     = en;
    assign out_valid = vld_reg[PipeDepth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PipeDepth-2:0], valid};
    end

    sc_t scx, scy, scz;

    exr_sincos u_sx (.clk(clk), .en(en), .angle(angle_x), .sc(scx));
    exr_sincos u_sy (.clk(clk), .en(en), .angle(angle_y), .sc(scy));
    exr_sincos u_sz (.clk(clk), .en(en), .angle(angle_z), .sc(scz));

    // Stage A: first products.
    q30_t sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, sxcy_reg, cxcy_reg;
    q30_t cxsz_reg, cxcz_reg, sxsz_reg, sxcz_reg;
    q30_t sy_reg, sz_reg, cz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxsy_reg <= mul_q30(scx.s, scy.s);
            cxsy_reg <= mul_q30(scx.c, scy.s);
            cycz_reg <= mul_q30(scy.c, scz.c);
            cysz_reg <= mul_q30(scy.c, scz.s);
            sxcy_reg <= mul_q30(scx.s, scy.c);
            cxcy_reg <= mul_q30(scx.c, scy.c);
            cxsz_reg <= mul_q30(scx.c, scz.s);
            cxcz_reg <= mul_q30(scx.c, scz.c);
            sxsz_reg <= mul_q30(scx.s, scz.s);
            sxcz_reg <= mul_q30(scx.s, scz.c);
            sy_reg   <= scy.s;
            sz_reg   <= scz.s;
            cz_reg   <= scz.c;
        end
    end

    // Stage B: triple products and sums.
    q30_t e_reg [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg[0] <= cycz_reg;
            e_reg[1] <= -cysz_reg;
            e_reg[2] <= sy_reg;
            e_reg[3] <= mul_q30(sxsy_reg, cz_reg) + cxsz_reg;
            e_reg[4] <= cxcz_reg - mul_q30(sxsy_reg, sz_reg);
            e_reg[5] <= -sxcy_reg;
            e_reg[6] <= sxsz_reg - mul_q30(cxsy_reg, cz_reg);
            e_reg[7] <= mul_q30(cxsy_reg, sz_reg) + sxcz_reg;
            e_reg[8] <= cxcy_reg;
        end
    end

    localparam int Sh = 30 - OutFracBits;

    function automatic logic signed [15:0] to_out(input q30_t v);
        logic signed [33:0] t;
        logic signed [33:0] lim;
        t   = (34'(v) + 34'(1 <<< (Sh - 1))) >>> Sh;
        lim = 34'(1) <<< OutFracBits;
        if (t > lim)
            t = lim;
        if (t < -lim)
            t = -lim;
        return t[15:0];
    endfunction

    logic signed [15:0] m_reg [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
                m_reg[i] <= to_out(e_reg[i]);
        end
    end

    assign m00 = m_reg[0];
    assign m01 = m_reg[1];
    assign m02 = m_reg[2];
    assign m10 = m_reg[3];
    assign m11 = m_reg[4];
    assign m12 = m_reg[5];
    assign m20 = m_reg[6];
    assign m21 = m_reg[7];
    assign m22 = m_reg[8];

    `EXR_ASSERT(a_ready_when_empty, !out_valid |-> ready, "pipeline blocked while output empty")
    `EXR_ASSERT_NEXT(a_hold_on_stall, out_valid && !out_ready, out_valid && $stable(m00),
        "stalled result changed")
    `EXR_ASSERT_NEXT(a_valid_shift, en, vld_reg[PipeDepth-1] == $past(vld_reg[PipeDepth-2]),
        "valid bit lost in pipeline")
    `EXR_ASSERT(a_sat, out_valid |-> (m22 <= 16'sd16384 && m22 >= -16'sd16384),
        "entry beyond saturation")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import exr_pkg::*;

    localparam int WatchdogLimit = 5000;

    typedef struct {
        logic signed [15:0] m [9];
    } matrix_t;

    logic               clk;
    logic               rst_n;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    matrix_t expected_matrices[$];
    int      error_count;
    int      idle_cycles;
    bit      drain_done;

    euler_xyz_to_rotation_matrix dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .ready     (ready),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .angle_z   (angle_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .m00       (m00),
        .m01       (m01),
        .m02       (m02),
        .m10       (m10),
        .m11       (m11),
        .m12       (m12),
        .m20       (m20),
        .m21       (m21),
        .m22       (m22)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint q30_product(input longint a, input longint b);
        return floor_shift(a * b, 30);
    endfunction

    // CORDIC sine and cosine of one angle field, Q30.
    task automatic angle_sin_cos(input logic signed [15:0] ang, output longint s,
                                 output longint c);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        longint arctan [CordicSteps];
        int     a;
        int     quadrant;
        arctan = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
        a = int'(ang) % FullTurn;
        if (a < 0)
            a += FullTurn;
        quadrant = a / QuarterTurn;
        z = longint'(a % QuarterTurn) * 512;
        x = CordicGain;
        y = 0;
        for (int i = 0; i < CordicSteps; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z -= arctan[i];
            end
            else
            begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z += arctan[i];
            end
            x = nx;
            y = ny;
        end
        case (quadrant)
            1:       begin s = x;  c = -y; end
            2:       begin s = -y; c = -x; end
            3:       begin s = -x; c = y;  end
            default: begin s = y;  c = x;  end
        endcase
    endtask

    function automatic logic signed [15:0] to_entry(input longint v);
        longint lim;
        int     sh;
        sh = 30 - OutFracBits;
        lim = longint'(1) << OutFracBits;
        if (sh > 0)
            v = floor_shift(v + (longint'(1) << (sh - 1)), sh);
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v[15:0];
    endfunction

    task automatic predict_matrix(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                  input logic signed [15:0] az, output matrix_t r);
        longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
        angle_sin_cos(ax, sx, cx);
        angle_sin_cos(ay, sy, cy);
        angle_sin_cos(az, sz, cz);
        sxsy = q30_product(sx, sy);
        cxsy = q30_product(cx, sy);
        r.m[0] = to_entry(q30_product(cy, cz));
        r.m[1] = to_entry(-q30_product(cy, sz));
        r.m[2] = to_entry(sy);
        r.m[3] = to_entry(q30_product(sxsy, cz) + q30_product(cx, sz));
        r.m[4] = to_entry(q30_product(cx, cz) - q30_product(sxsy, sz));
        r.m[5] = to_entry(-q30_product(sx, cy));
        r.m[6] = to_entry(q30_product(sx, sz) - q30_product(cxsy, cz));
        r.m[7] = to_entry(q30_product(cxsy, sz) + q30_product(sx, cz));
        r.m[8] = to_entry(q30_product(cx, cy));
    endtask

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Drive one angle triple and hold it until the transfer.
    task automatic send_angles(input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic signed [15:0] az);
        matrix_t r;
        int      gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        valid   <= 1'b1;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        predict_matrix(ax, ay, az, r);
        do
            @(posedge clk);
        while (!ready);
        expected_matrices = {expected_matrices, r};
    endtask

    function automatic logic signed [15:0] random_angle();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom());
            1:       return 16'(($urandom_range(0, 8) - 4) * QuarterTurn + $urandom_range(0, 2) - 1);
            default: return 16'($urandom_range(0, 46080) - 23040);
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [15:0] picks [12];
        picks = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd11520, -16'sd11520, 16'sd1,
                  -16'sd1, 16'sd32767, -16'sd32768, 16'sd11519, 16'sd5760, -16'sd19456};
        foreach (picks[i])
            send_angles(picks[i], picks[(i + 3) % 12], picks[(i + 7) % 12]);
        send_angles(16'sd32767, 16'sd32767, 16'sd32767);
        send_angles(-16'sd32768, -16'sd32768, -16'sd32768);
        send_angles(16'sd0, 16'sd11520, 16'sd0);
        send_angles(16'sd0, -16'sd11520, 16'sd0);
        send_angles(16'sd11520, 16'sd11520, 16'sd11520);
        send_angles(16'sd23040, 16'sd0, -16'sd23040);
        send_angles(16'h5555, 16'hAAAA, 16'h0F0F);
    endtask

    task automatic test_random_poses();
        for (int n = 0; n < 1830; n++)
            send_angles(random_angle(), random_angle(), random_angle());
    endtask

    // Output side: random stall per result, and field checks.
    initial
    begin
        int stall;
        matrix_t e;
        logic signed [15:0] got [9];
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
            if (expected_matrices.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                e = expected_matrices.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got[k] !== e.m[k])
                        report_mismatch($sformatf("m%0d%0d got %0d want %0d",
                                                  k / 3, k % 3, got[k], e.m[k]));
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((valid && ready) || (out_valid && out_ready) || drain_done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        error_count = 0;
        drain_done  = 1'b0;
        rst_n   <= 1'b0;
        valid   <= 1'b0;
        angle_x <= '0;
        angle_y <= '0;
        angle_z <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_random_poses();
        valid <= 1'b0;
        while (expected_matrices.size() != 0)
            @(posedge clk);
        drain_done = 1'b1;
        repeat (PipeDepth * 3) @(posedge clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
